/* hdl/scaled_dot_product_attention_tile_defines.svh */
// assertion macros for the attention tile checker
`ifndef SCALED_DOT_PRODUCT_ATTENTION_TILE_DEFINES_SVH
`define SCALED_DOT_PRODUCT_ATTENTION_TILE_DEFINES_SVH

// same-cycle implication
`define SDPAT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sdpat check failed");

// next-cycle implication
`define SDPAT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sdpat check failed");

`endif

/* hdl/sdpat_pkg.sv */
package sdpat_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int MAX_COLS   = 64;
    localparam int ELEM_WIDTH = 16;

    localparam logic [1:0] OP_LOAD_Q  = 2'd0;
    localparam logic [1:0] OP_LOAD_K  = 2'd1;
    localparam logic [1:0] OP_LOAD_V  = 2'd2;
    localparam logic [1:0] OP_COMPUTE = 2'd3;

    localparam logic [1:0] CFG_ROWS  = 2'd0;
    localparam logic [1:0] CFG_COLS  = 2'd1;
    localparam logic [1:0] CFG_SCALE = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [5:0]         row_index;
        logic [5:0]         col_index;
        logic signed [15:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic [5:0]         out_row;
        logic [5:0]         out_col;
        logic signed [15:0] out_value;
        logic               out_last;
    } t_out_item;

endpackage

/* hdl/scaled_dot_product_attention_tile.sv */
// load items are written to their store when accepted; a compute item steps through the
// dot, scale, exp, divide, output and emit phases in turn and waits in emit on output stall
// throughput: one item at a time, set by the single shared multiplier and
// the bit-serial divider (one quotient bit per cycle)
// reset: synchronous active-low; registers return to 64 rows, 64 cols, scale 8192;
// q/k/v stores hold undefined data until loaded
module scaled_dot_product_attention_tile
    import sdpat_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DOT   = 7'b0000010,
        S_SCALE = 7'b0000100,
        S_EXP   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_EMIT  = 7'b1000000
    } t_state;

    t_state r_state;
    logic [2:0]  r_sub;
    logic [5:0]  r_row, r_k, r_c, r_bit;
    logic [6:0]  r_rows, r_cols;
    logic [15:0] r_scale;
    logic signed [39:0] r_acc;
    logic signed [56:0] r_prod;
    logic signed [27:0] r_max;
    logic [22:0] r_sum;
    logic [11:0] r_f;
    logic [4:0]  r_n;
    logic        r_nbig;
    logic [27:0] r_t1;
    logic [32:0] r_num;
    logic [22:0] r_rem;
    logic        r_ovalid;
    t_out_item   r_out;

    logic signed [15:0] q_mem [0:4095];
    logic signed [15:0] k_mem [0:4095];
    logic signed [15:0] v_mem [0:4095];
    logic signed [27:0] score_mem [0:63];
    logic [16:0]        prob_mem [0:63];
    logic signed [15:0] r_q_rd, r_k_rd, r_v_rd;
    logic signed [27:0] r_s_rd;
    logic [16:0]        r_p_rd;

    logic [6:0]  rows_eff, cols_eff;
    logic        k_last, c_last, accept;
    logic signed [38:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [56:0] mul_p;
    logic signed [56:0] sc_sum;
    logic signed [27:0] score;
    logic [28:0] diff;
    logic [43:0] y_sum;
    logic [29:0] y;
    logic [17:0] m;
    logic [16:0] e;
    logic [23:0] t_div;
    logic        ge;
    logic [22:0] rem_n;
    logic [32:0] num_n;
    logic        p_we;
    logic [16:0] p_wd;
    logic        can_load;
    logic signed [39:0] rnd_sum;
    logic signed [23:0] o_full;
    logic signed [15:0] o_sat;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;
    assign accept      = i_in_valid && !o_in_stall;

    always_comb begin
        rows_eff = r_rows;
        if (r_rows == 7'd0) rows_eff = 7'd1;
        else if (r_rows > 7'd64) rows_eff = 7'd64;
        cols_eff = r_cols;
        if (r_cols == 7'd0) cols_eff = 7'd1;
        else if (r_cols > 7'd64) cols_eff = 7'd64;
    end

    assign k_last = ({1'b0, r_k} == rows_eff - 7'd1);
    assign c_last = ({1'b0, r_c} == cols_eff - 7'd1);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_DOT: begin
                mul_a = {{23{r_q_rd[15]}}, r_q_rd};
                mul_b = {{2{r_k_rd[15]}}, r_k_rd};
            end
            S_SCALE: begin
                mul_a = r_acc[38:0];
                mul_b = {2'b00, r_scale};
            end
            S_EXP: begin
                case (r_sub)
                    3'd1: begin
                        mul_a = {10'd0, diff};
                        mul_b = 18'sd23637;
                    end
                    3'd3: begin
                        mul_a = {27'd0, r_f};
                        mul_b = 18'sd43025;
                    end
                    3'd4: begin
                        mul_a = {27'd0, r_f};
                        mul_b = {6'd0, r_f};
                    end
                    3'd5: begin
                        mul_a = {15'd0, r_prod[23:0]};
                        mul_b = 18'sd10257;
                    end
                    default: ;
                endcase
            end
            S_OUT: begin
                mul_a = {{23{r_v_rd[15]}}, r_v_rd};
                mul_b = {1'b0, r_p_rd};
            end
            default: ;
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign sc_sum = r_prod + 57'sd134217728;
    assign score  = sc_sum[55:28];
    assign diff   = 29'({r_max[27], r_max} - {r_s_rd[27], r_s_rd});
    assign y_sum  = r_prod[43:0] + 44'd8192;
    assign y      = y_sum[43:14];
    assign m      = 18'd65536 - {2'b00, r_t1[27:12]} + {4'd0, r_prod[37:24]};
    assign e      = r_nbig ? 17'd0 : (m[16:0] >> r_n);

    assign t_div = {r_rem, r_num[32]};
    assign ge    = (t_div >= {1'b0, r_sum});
    assign rem_n = ge ? 23'(t_div - {1'b0, r_sum}) : t_div[22:0];
    assign num_n = {r_num[31:0], ge};

    assign rnd_sum = r_acc + 40'sd32768;
    assign o_full  = rnd_sum[39:16];
    always_comb begin
        if (o_full > 24'sd32767) o_sat = 16'sh7fff;
        else if (o_full < -24'sd32768) o_sat = 16'sh8000;
        else o_sat = o_full[15:0];
    end

    assign can_load = !r_ovalid || !i_out_stall;

    always_comb begin
        p_we = 1'b0;
        p_wd = e;
        if (r_state == S_EXP && r_sub == 3'd6) begin
            p_we = 1'b1;
        end else if (r_state == S_DIV && r_sub == 3'd2 && r_bit == 6'd32) begin
            p_we = 1'b1;
            p_wd = num_n[16:0];
        end
    end

    // stores
    always_ff @(posedge i_clk) begin
        if (accept && i_in_item.operation == OP_LOAD_Q)
            q_mem[{i_in_item.row_index, i_in_item.col_index}] <= i_in_item.element_value;
        if (accept && i_in_item.operation == OP_LOAD_K)
            k_mem[{i_in_item.row_index, i_in_item.col_index}] <= i_in_item.element_value;
        if (accept && i_in_item.operation == OP_LOAD_V)
            v_mem[{i_in_item.row_index, i_in_item.col_index}] <= i_in_item.element_value;
        r_q_rd <= q_mem[{r_row, r_c}];
        r_k_rd <= k_mem[{r_k, r_c}];
        r_v_rd <= v_mem[{r_k, r_c}];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCALE && r_sub == 3'd1)
            score_mem[r_k] <= score;
        if (p_we)
            prob_mem[r_k] <= p_wd;
        r_s_rd <= score_mem[r_k];
        r_p_rd <= prob_mem[r_k];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sub    <= '0;
            r_ovalid <= 1'b0;
            r_rows   <= 7'd64;
            r_cols   <= 7'd64;
            r_scale  <= 16'd8192;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ROWS:  r_rows  <= i_cfg_data[6:0];
                    CFG_COLS:  r_cols  <= i_cfg_data[6:0];
                    CFG_SCALE: r_scale <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_EMIT && can_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && i_in_item.operation == OP_COMPUTE &&
                        {1'b0, i_in_item.row_index} < rows_eff) begin
                        r_row   <= i_in_item.row_index;
                        r_k     <= '0;
                        r_c     <= '0;
                        r_acc   <= '0;
                        r_sub   <= '0;
                        r_state <= S_DOT;
                    end
                end
                S_DOT: begin
                    if (r_sub == 3'd2) begin
                        r_acc <= r_acc + {{8{r_prod[31]}}, r_prod[31:0]};
                        r_sub <= '0;
                        if (c_last) begin
                            r_c     <= '0;
                            r_state <= S_SCALE;
                        end else begin
                            r_c <= r_c + 6'd1;
                        end
                    end else begin
                        r_sub <= r_sub + 3'd1;
                    end
                end
                S_SCALE: begin
                    if (r_sub == 3'd1) begin
                        if (r_k == 6'd0 || score > r_max) r_max <= score;
                        r_acc <= '0;
                        r_sub <= '0;
                        if (k_last) begin
                            r_k     <= '0;
                            r_sum   <= '0;
                            r_state <= S_EXP;
                        end else begin
                            r_k     <= r_k + 6'd1;
                            r_state <= S_DOT;
                        end
                    end else begin
                        r_sub <= r_sub + 3'd1;
                    end
                end
                S_EXP: begin
                    if (r_sub == 3'd2) begin
                        r_f    <= y[11:0];
                        r_n    <= y[16:12];
                        r_nbig <= (|y[29:17]) || (y[16:12] >= 5'd17);
                    end
                    if (r_sub == 3'd4) r_t1 <= r_prod[27:0];
                    if (r_sub == 3'd6) begin
                        r_sum <= r_sum + {6'd0, e};
                        r_sub <= '0;
                        if (k_last) begin
                            r_k     <= '0;
                            r_state <= S_DIV;
                        end else begin
                            r_k <= r_k + 6'd1;
                        end
                    end else begin
                        r_sub <= r_sub + 3'd1;
                    end
                end
                S_DIV: begin
                    case (r_sub)
                        3'd0: r_sub <= 3'd1;
                        3'd1: begin
                            r_num <= {r_p_rd, 16'd0} + {11'd0, r_sum[22:1]};
                            r_rem <= '0;
                            r_bit <= '0;
                            r_sub <= 3'd2;
                        end
                        default: begin
                            r_num <= num_n;
                            r_rem <= rem_n;
                            r_bit <= r_bit + 6'd1;
                            if (r_bit == 6'd32) begin
                                r_sub <= '0;
                                if (k_last) begin
                                    r_k     <= '0;
                                    r_c     <= '0;
                                    r_acc   <= '0;
                                    r_state <= S_OUT;
                                end else begin
                                    r_k <= r_k + 6'd1;
                                end
                            end
                        end
                    endcase
                end
                S_OUT: begin
                    if (r_sub == 3'd2) begin
                        r_acc <= r_acc + {{6{r_prod[33]}}, r_prod[33:0]};
                        r_sub <= '0;
                        if (k_last) begin
                            r_k     <= '0;
                            r_state <= S_EMIT;
                        end else begin
                            r_k <= r_k + 6'd1;
                        end
                    end else begin
                        r_sub <= r_sub + 3'd1;
                    end
                end
                S_EMIT: begin
                    if (can_load) begin
                        r_out.out_row   <= r_row;
                        r_out.out_col   <= r_c;
                        r_out.out_value <= o_sat;
                        r_out.out_last  <= c_last;
                        r_acc           <= '0;
                        if (c_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_c     <= r_c + 6'd1;
                            r_state <= S_OUT;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hdl/sdpat_checker.sv */
`include "scaled_dot_product_attention_tile_defines.svh"

module sdpat_checker
    import sdpat_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_item,
    input logic      i_cfg_valid,
    input logic      o_cfg_ready
);

    // a load never holds the input side
    `SDPAT_ASSERT_NEXT(a_load_quick, i_in_valid && !o_in_stall && i_in_item.operation != OP_COMPUTE, !o_in_stall)

    // nothing follows the last element of a row straight away
    `SDPAT_ASSERT_NEXT(a_last_ends, o_out_valid && !i_out_stall && o_out_item.out_last, !o_out_valid)

    // configuration port is always open
    `SDPAT_ASSERT_NOW(a_cfg_ready, i_cfg_valid, o_cfg_ready)

    // a stalled result holds
    `SDPAT_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

endmodule

bind scaled_dot_product_attention_tile sdpat_checker u_sdpat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);
